### hdl/wsu_pkg.sv
// Package for the WebSocket frame unmasker: frame constants, result kinds
// and the result descriptor type. No dependencies.
package wsu_pkg;

    localparam int MAX_PAYLOAD_BYTES = 125;
    localparam int HDR_BYTES         = 6;
    localparam int MIN_CHUNK         = 7;
    localparam int BUF_BYTES         = MAX_PAYLOAD_BYTES + 2;

    localparam logic [6:0] OP_CONT  = 7'd0;
    localparam logic [6:0] OP_TEXT  = 7'd1;
    localparam logic [6:0] OP_BIN   = 7'd2;
    localparam logic [6:0] OP_CLOSE = 7'd8;
    localparam logic [6:0] OP_PING  = 7'd9;

    localparam logic [7:0] PONG_HDR = 8'h8A;
    localparam logic [7:0] CLOSED_BYTE = 8'h00;
    // Error frame, sent from entry 0 upward.
    localparam logic [3:0][7:0] ERR_FRAME = {8'h00, 8'h80, 8'h02, 8'h82};

    typedef enum logic [1:0] {
        KIND_APP    = 2'd0,
        KIND_PONG   = 2'd1,
        KIND_ERR    = 2'd2,
        KIND_CLOSED = 2'd3
    } kind_t;

    // Up to four result beats caused by one input beat.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [3:0]      first;
        logic [1:0]      last_idx;
        kind_t           kind;
        logic [3:0]      opcode;
        logic            term;
    } desc_t;

endpackage

### hdl/websocket_frame_unmasker_core.sv
// Top level of the WebSocket frame unmasker: header capture, payload unmask
// and result sequencing. Depends on wsu_pkg.
//
// The first result of an input beat is shown in the cycle after it is accepted.
// One input beat per cycle while the result register is free; a beat with more
// than one result holds the input until its final result leaves, one beat per
// cycle while out_stall is low. Async active-low reset clears the frame state
// and opens the link; the mask key is undefined until a header loads it.
module websocket_frame_unmasker_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       chunk_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic [3:0] out_opcode,
    output logic       first_of_frame,
    output logic       last,
    output logic       terminated
);
    import wsu_pkg::*;

    localparam logic [6:0] BufBytes = 7'(BUF_BYTES);
    localparam logic [6:0] HdrBytes = 7'(HDR_BYTES);
    localparam logic [6:0] MinChunk = 7'(MIN_CHUNK);
    localparam logic [6:0] MaxLen   = 7'(MAX_PAYLOAD_BYTES);

    logic [6:0] bp_reg, bp_next;
    logic [6:0] op_reg, op_next;
    logic [6:0] len_reg, len_next;
    logic [6:0] dc_reg, dc_next;
    logic       closed_reg, closed_next;
    logic [7:0] mask_reg [4];
    logic       mask_we;
    logic [1:0] mask_idx;

    logic       vld_reg, vld_next;
    logic [1:0] idx_reg, idx_next;
    desc_t      desc_reg, desc_next;
    logic       load;

    logic       in_acc;
    logic       out_acc;
    logic [7:0] unmasked;

    assign out_acc  = vld_reg && !out_stall;
    // The result register frees up when its final beat leaves this cycle.
    assign in_stall = vld_reg && !(out_acc && (idx_reg == desc_reg.last_idx));
    assign in_acc   = in_valid && !in_stall;
    assign unmasked = rx_byte ^ mask_reg[dc_reg[1:0]];

    always_comb
    begin
        bp_next     = bp_reg;
        op_next     = op_reg;
        len_next    = len_reg;
        dc_next     = dc_reg;
        closed_next = closed_reg;
        mask_we     = 1'b0;
        mask_idx    = 2'(bp_reg[1:0] - 2'd2);
        load        = 1'b0;
        desc_next   = desc_reg;
        desc_next.first    = 4'b0000;
        desc_next.last_idx = 2'd0;
        desc_next.term     = 1'b0;

        if (in_acc && !closed_reg)
        begin
            if (bp_reg < BufBytes)
            begin
                if (bp_reg == 7'd0)
                begin
                    op_next = rx_byte[6:0];
                end
                else if (bp_reg == 7'd1)
                begin
                    len_next = rx_byte[6:0];
                end
                else if (bp_reg < HdrBytes)
                begin
                    mask_we = 1'b1;
                end
                else if (op_reg == OP_CLOSE)
                begin
                    if (bp_reg == HdrBytes)
                    begin
                        load              = 1'b1;
                        desc_next.data[0] = CLOSED_BYTE;
                        desc_next.kind    = KIND_CLOSED;
                        desc_next.term    = 1'b1;
                        closed_next       = 1'b1;
                    end
                end
                else if (op_reg == OP_CONT || op_reg == OP_TEXT || op_reg == OP_BIN)
                begin
                    if (dc_reg < len_reg)
                    begin
                        load               = 1'b1;
                        desc_next.data[0]  = unmasked;
                        desc_next.first[0] = (dc_reg == 7'd0);
                        desc_next.kind     = KIND_APP;
                        dc_next            = dc_reg + 7'd1;
                    end
                end
                else if (op_reg == OP_PING && len_reg <= MaxLen)
                begin
                    desc_next.kind = KIND_PONG;
                    if (bp_reg == HdrBytes)
                    begin
                        // Pong header goes out ahead of the first echoed byte.
                        load               = 1'b1;
                        desc_next.data[0]  = PONG_HDR;
                        desc_next.data[1]  = {1'b0, len_reg};
                        desc_next.data[2]  = unmasked;
                        desc_next.last_idx = (dc_reg < len_reg) ? 2'd2 : 2'd1;
                        desc_next.first[2] = (dc_reg == 7'd0) && (dc_reg < len_reg);
                        if (dc_reg < len_reg)
                        begin
                            dc_next = dc_reg + 7'd1;
                        end
                    end
                    else if (dc_reg < len_reg)
                    begin
                        load               = 1'b1;
                        desc_next.data[0]  = unmasked;
                        desc_next.first[0] = (dc_reg == 7'd0);
                        dc_next            = dc_reg + 7'd1;
                    end
                end
                bp_next = bp_reg + 7'd1;
            end

            if (chunk_end && !closed_next)
            begin
                // A short chunk only ever holds header bytes, so the error
                // frame never competes with payload results.
                if (bp_next < MinChunk)
                begin
                    load               = 1'b1;
                    desc_next.data     = ERR_FRAME;
                    desc_next.first    = 4'b0000;
                    desc_next.last_idx = 2'd3;
                    desc_next.kind     = KIND_ERR;
                    desc_next.term     = 1'b1;
                    closed_next        = 1'b1;
                end
                bp_next = 7'd0;
                dc_next = 7'd0;
            end
        end
        desc_next.opcode = op_next[3:0];

        vld_next = vld_reg;
        idx_next = idx_reg;
        if (load)
        begin
            vld_next = 1'b1;
            idx_next = 2'd0;
        end
        else if (out_acc)
        begin
            if (idx_reg == desc_reg.last_idx)
            begin
                vld_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg     <= '0;
            op_reg     <= '0;
            len_reg    <= '0;
            dc_reg     <= '0;
            closed_reg <= 1'b0;
            vld_reg    <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            bp_reg     <= bp_next;
            op_reg     <= op_next;
            len_reg    <= len_next;
            dc_reg     <= dc_next;
            closed_reg <= closed_next;
            vld_reg    <= vld_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc_next;
        end
        if (mask_we)
        begin
            mask_reg[mask_idx] <= rx_byte;
        end
    end

    assign out_valid      = vld_reg;
    assign out_byte       = desc_reg.data[idx_reg];
    assign out_kind       = desc_reg.kind;
    assign out_opcode     = desc_reg.opcode;
    assign first_of_frame = desc_reg.first[idx_reg];
    assign last           = (idx_reg == desc_reg.last_idx);
    assign terminated     = desc_reg.term;

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_term_means_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && terminated) |-> closed_reg)
        else $error("termination beat while link still open");

    a_first_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_of_frame) |-> (out_kind == KIND_APP || out_kind == KIND_PONG))
        else $error("first_of_frame on a non-payload beat");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg <= desc_reg.last_idx))
        else $error("result index past last beat");

    a_count_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        dc_reg <= len_reg)
        else $error("delivered count exceeds header length");

endmodule
